### sv/i2c_master_bit_engine_macros.svh
// Assertion macros shared by the I2C master bit engine checker.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/i2cm_pkg.sv
// Types, codes and phase-entry function for the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

  typedef logic [2:0] op_t;

  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_START = 3'd1;
  localparam op_t OP_STOP  = 3'd2;
  localparam op_t OP_WRITE = 3'd3;
  localparam op_t OP_READ  = 3'd4;

  typedef logic [0:0] reg_idx_t;

  localparam reg_idx_t REG_PHASE_TICKS = 1'd0;
  localparam reg_idx_t REG_ACK_TIMEOUT = 1'd1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd144;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd100;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  // S: start, T: stop, W: write bit, A: ack check, R: read bit, K: ack drive
  typedef enum logic [14:0] {
    PH_IDLE = 15'h0001,
    PH_S1   = 15'h0002,
    PH_S2   = 15'h0004,
    PH_T1   = 15'h0008,
    PH_T2   = 15'h0010,
    PH_W1   = 15'h0020,
    PH_W2   = 15'h0040,
    PH_W3   = 15'h0080,
    PH_A1   = 15'h0100,
    PH_A2   = 15'h0200,
    PH_A3   = 15'h0400,
    PH_R1   = 15'h0800,
    PH_R2   = 15'h1000,
    PH_K1   = 15'h2000,
    PH_K2   = 15'h4000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] timer;
    logic [15:0] poll;
    logic        ack_choice;
    logic        nack;
    logic [7:0]  rx;
    logic        scl;
    logic        sda;
    logic        oe;
  } eng_st_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       nack_error;
  } res_t;

  // Enter a bus phase: load the hold timer and set the line levels.
  function automatic eng_st_t phase_enter(eng_st_t s, phase_t ph, logic [15:0] ticks);
    eng_st_t r;
    r = s;
    r.phase = ph;
    r.timer = (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
    case (ph)
      PH_S1: begin r.oe = 1'b1; r.sda = 1'b1; r.scl = 1'b1; end
      PH_S2: r.sda = 1'b0;
      PH_T1: begin r.oe = 1'b1; r.scl = 1'b0; r.sda = 1'b0; end
      PH_T2: begin r.scl = 1'b1; r.sda = 1'b1; end
      PH_W1: begin r.oe = 1'b1; r.scl = 1'b0; r.sda = s.shreg[7]; end
      PH_W2: r.scl = 1'b1;
      PH_W3: r.scl = 1'b0;
      PH_A1: begin r.oe = 1'b0; r.sda = 1'b1; r.scl = 1'b0; end
      PH_A2: r.scl = 1'b1;
      PH_A3: r.poll = 16'd0;
      PH_R1: begin r.oe = 1'b0; r.sda = 1'b1; r.scl = 1'b0; end
      PH_R2: r.scl = 1'b1;
      PH_K1: begin r.scl = 1'b0; r.oe = 1'b1; r.sda = ~s.ack_choice; end
      PH_K2: r.scl = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/i2c_master_bit_engine.sv
// I2C master bit engine: one timer tick per transaction, bus levels and status out.
//
//   channel | dir | ports
//   --------+-----+---------------------------------------------------------------
//   in      | in  | in_valid in_stall in_op in_tx_byte in_send_ack in_sda_sample
//   out     | out | out_valid out_stall out_scl_level out_sda_level out_sda_drive
//           |     |   out_busy_res out_done_res out_rx_byte out_nack_error
//   cfg     | in  | cfg_we cfg_index cfg_data
//
// One tick per clock while in_stall is low: each accepted transaction updates the phase
// state register, and its result is registered into the output register or the skid register.
// A skid register behind the output register lets a tick be taken while a result
// waits; in_stall rises only when both hold results.
// Synchronous active-low reset: idle, SCL and SDA driven high, registers at defaults.
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire i2cm_pkg::op_t     in_op,
  input  wire logic [7:0]        in_tx_byte,
  input  wire logic              in_send_ack,
  input  wire logic              in_sda_sample,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_scl_level,
  output logic                   out_sda_level,
  output logic                   out_sda_drive,
  output logic                   out_busy_res,
  output logic                   out_done_res,
  output logic [7:0]             out_rx_byte,
  output logic                   out_nack_error,
  input  wire logic              cfg_we,
  input  wire i2cm_pkg::reg_idx_t cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import i2cm_pkg::*;

  logic [15:0] phase_ticks_r;
  logic [15:0] ack_timeout_r;
  eng_st_t     st_r, st_nxt;
  logic        done_nxt;
  res_t        res_nxt;
  res_t        out_r, out_nxt;
  res_t        skid_r, skid_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  logic        in_acc, out_take, out_free;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_take = out_vld_r && !out_stall;
  assign out_free = !out_vld_r || out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_TICKS: phase_ticks_r <= cfg_data;
        REG_ACK_TIMEOUT: ack_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick step
  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    if (st_r.phase == PH_IDLE) begin
      case (in_op)
        OP_START: st_nxt = phase_enter(st_r, PH_S1, phase_ticks_r);
        OP_STOP:  st_nxt = phase_enter(st_r, PH_T1, phase_ticks_r);
        OP_WRITE: begin
          st_nxt         = st_r;
          st_nxt.shreg   = in_tx_byte;
          st_nxt.bit_cnt = 4'd0;
          st_nxt.nack    = 1'b0;
          st_nxt         = phase_enter(st_nxt, PH_W1, phase_ticks_r);
        end
        OP_READ: begin
          st_nxt            = st_r;
          st_nxt.shreg      = 8'd0;
          st_nxt.bit_cnt    = 4'd0;
          st_nxt.ack_choice = in_send_ack;
          st_nxt            = phase_enter(st_nxt, PH_R1, phase_ticks_r);
        end
        default: ;
      endcase
    end else if (st_r.phase == PH_A3) begin
      if (!in_sda_sample) begin
        st_nxt.scl   = 1'b0;
        st_nxt.phase = PH_IDLE;
        st_nxt.timer = 16'd0;
        done_nxt     = 1'b1;
      end else if (st_r.poll >= ack_timeout_r) begin
        st_nxt.nack = 1'b1;
        st_nxt      = phase_enter(st_nxt, PH_T1, phase_ticks_r);
      end else begin
        st_nxt.poll = st_r.poll + 16'd1;
      end
    end else if (st_r.timer != 16'd0) begin
      st_nxt.timer = st_r.timer - 16'd1;
    end else begin
      case (st_r.phase)
        PH_S1: st_nxt = phase_enter(st_r, PH_S2, phase_ticks_r);
        PH_T1: st_nxt = phase_enter(st_r, PH_T2, phase_ticks_r);
        PH_W1: st_nxt = phase_enter(st_r, PH_W2, phase_ticks_r);
        PH_W2: st_nxt = phase_enter(st_r, PH_W3, phase_ticks_r);
        PH_A1: st_nxt = phase_enter(st_r, PH_A2, phase_ticks_r);
        PH_A2: st_nxt = phase_enter(st_r, PH_A3, phase_ticks_r);
        PH_R1: st_nxt = phase_enter(st_r, PH_R2, phase_ticks_r);
        PH_K1: st_nxt = phase_enter(st_r, PH_K2, phase_ticks_r);
        PH_S2, PH_K2: begin
          st_nxt.scl   = 1'b0;
          st_nxt.phase = PH_IDLE;
          st_nxt.timer = 16'd0;
          done_nxt     = 1'b1;
        end
        PH_T2: begin
          st_nxt.phase = PH_IDLE;
          st_nxt.timer = 16'd0;
          done_nxt     = 1'b1;
        end
        PH_W3: begin
          st_nxt.shreg   = {st_r.shreg[6:0], 1'b0};
          st_nxt.bit_cnt = st_r.bit_cnt + 4'd1;
          st_nxt = phase_enter(st_nxt,
                               (st_nxt.bit_cnt >= BITS_PER_BYTE) ? PH_A1 : PH_W1,
                               phase_ticks_r);
        end
        PH_R2: begin
          // sample the data bit at the end of the SCL high hold
          st_nxt.shreg   = {st_r.shreg[6:0], in_sda_sample};
          st_nxt.bit_cnt = st_r.bit_cnt + 4'd1;
          if (st_nxt.bit_cnt >= BITS_PER_BYTE) begin
            st_nxt.rx = st_nxt.shreg;
            st_nxt    = phase_enter(st_nxt, PH_K1, phase_ticks_r);
          end else begin
            st_nxt = phase_enter(st_nxt, PH_R1, phase_ticks_r);
          end
        end
        default: st_nxt.phase = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res_nxt.scl_level  = st_nxt.scl;
    res_nxt.sda_level  = st_nxt.sda;
    res_nxt.sda_drive  = st_nxt.oe;
    res_nxt.busy       = (st_nxt.phase != PH_IDLE);
    res_nxt.done       = done_nxt;
    res_nxt.rx_byte    = st_nxt.rx;
    res_nxt.nack_error = st_nxt.nack;
  end

  // Output register with skid stage
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (out_free) begin
      out_vld_nxt  = skid_vld_r || in_acc;
      out_nxt      = skid_vld_r ? skid_r : res_nxt;
      skid_vld_nxt = 1'b0;
    end else if (in_acc) begin
      skid_nxt     = res_nxt;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_IDLE;
      st_r.bit_cnt    <= 4'd0;
      st_r.shreg      <= 8'd0;
      st_r.timer      <= 16'd0;
      st_r.poll       <= 16'd0;
      st_r.ack_choice <= 1'b0;
      st_r.nack       <= 1'b0;
      st_r.rx         <= 8'd0;
      st_r.scl        <= 1'b1;
      st_r.sda        <= 1'b1;
      st_r.oe         <= 1'b1;
      out_vld_r       <= 1'b0;
      skid_vld_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_scl_level  = out_r.scl_level;
  assign out_sda_level  = out_r.sda_level;
  assign out_sda_drive  = out_r.sda_drive;
  assign out_busy_res   = out_r.busy;
  assign out_done_res   = out_r.done;
  assign out_rx_byte    = out_r.rx_byte;
  assign out_nack_error = out_r.nack_error;

endmodule

`default_nettype wire

### sv/i2cm_checker.sv
// Port-level checker for the I2C master bit engine, bound to the top level.
`default_nettype none

`include "i2c_master_bit_engine_macros.svh"

module i2cm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire i2cm_pkg::op_t      in_op,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_busy_res,
  input wire logic               out_done_res
);
  import i2cm_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r;
  logic       prev_busy_r;
  logic       idle_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track transactions in flight, the busy flag of the last result,
  // and whether the engine was idle as of the last result taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 2'd0;
      prev_busy_r <= 1'b0;
      idle_r      <= 1'b1;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        prev_busy_r <= out_busy_res;
        idle_r      <= !out_busy_res;
      end
    end
  end

  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `I2CM_ASSERT_NOW(a_no_phantom, out_valid, pend_r != 2'd0, "result without a tick")
  `I2CM_ASSERT_NOW(a_pend_bound, 1'b1, pend_r <= 2'd2, "more than two ticks in flight")
  `I2CM_ASSERT_NOW(a_done_after_busy, out_acc && out_done_res, prev_busy_r && !out_busy_res,
                   "done without a command in progress")
  `I2CM_ASSERT_NOW(a_start_busy, out_acc && pend_r == 2'd1 && idle_r && $past(in_acc)
                   && ($past(in_op) == OP_START || $past(in_op) == OP_STOP), out_busy_res,
                   "start or stop on idle engine did not go busy")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the I2C master bit engine: per-tick bus level and status checks.
module testbench;
  import i2cm_pkg::*;

  // op codes with no command behind them
  localparam op_t OP_UNUSED5 = 3'd5;
  localparam op_t OP_UNUSED7 = 3'd7;

  class bus_tick_board;
    logic [15:0] phase_ticks;
    logic [15:0] ack_timeout;
    phase_t      ph;
    logic [3:0]  bits;
    logic [7:0]  shreg;
    logic [15:0] timer;
    logic [15:0] polls;
    logic        ack_sel;
    logic        nack;
    logic [7:0]  rx;
    logic        scl;
    logic        sda;
    logic        oe;
    res_t        levels_due[$];
    int          errors;

    function new();
      phase_ticks = PHASE_TICKS_RST;
      ack_timeout = ACK_TIMEOUT_RST;
      ph = PH_IDLE;
      bits = '0;
      shreg = '0;
      timer = '0;
      polls = '0;
      ack_sel = 1'b0;
      nack = 1'b0;
      rx = '0;
      scl = 1'b1;
      sda = 1'b1;
      oe = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] value);
      if (idx == REG_PHASE_TICKS) phase_ticks = value;
      else ack_timeout = value;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function void enter_phase(phase_t p);
      ph = p;
      timer = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;
      case (p)
        PH_S1: begin oe = 1'b1; sda = 1'b1; scl = 1'b1; end
        PH_S2: sda = 1'b0;
        PH_T1: begin oe = 1'b1; scl = 1'b0; sda = 1'b0; end
        PH_T2: begin scl = 1'b1; sda = 1'b1; end
        PH_W1: begin oe = 1'b1; scl = 1'b0; sda = shreg[7]; end
        PH_W2: scl = 1'b1;
        PH_W3: scl = 1'b0;
        PH_A1: begin oe = 1'b0; sda = 1'b1; scl = 1'b0; end
        PH_A2: scl = 1'b1;
        PH_A3: polls = 16'd0;
        PH_R1: begin oe = 1'b0; sda = 1'b1; scl = 1'b0; end
        PH_R2: scl = 1'b1;
        PH_K1: begin scl = 1'b0; oe = 1'b1; sda = ~ack_sel; end
        PH_K2: scl = 1'b1;
        default: ;
      endcase
    endfunction

    function void note_tick(op_t op, logic [7:0] txb, logic sack, logic sda_in);
      logic done;
      res_t r;
      done = 1'b0;
      if (ph == PH_IDLE) begin
        case (op)
          OP_START: enter_phase(PH_S1);
          OP_STOP:  enter_phase(PH_T1);
          OP_WRITE: begin
            shreg = txb;
            bits = '0;
            nack = 1'b0;
            enter_phase(PH_W1);
          end
          OP_READ: begin
            shreg = '0;
            bits = '0;
            ack_sel = sack;
            enter_phase(PH_R1);
          end
          default: ;
        endcase
      end else if (ph == PH_A3) begin
        if (!sda_in) begin
          scl = 1'b0;
          done = 1'b1;
        end else if (polls >= ack_timeout) begin
          nack = 1'b1;
          enter_phase(PH_T1);
        end else begin
          polls = polls + 16'd1;
        end
      end else if (timer != 16'd0) begin
        timer = timer - 16'd1;
      end else if (ph == PH_R2) begin
        // take the data bit as the SCL high phase ends
        shreg = {shreg[6:0], sda_in};
        bits = bits + 4'd1;
        if (bits >= BITS_PER_BYTE) begin
          rx = shreg;
          enter_phase(PH_K1);
        end else begin
          enter_phase(PH_R1);
        end
      end else begin
        case (ph)
          PH_S1: enter_phase(PH_S2);
          PH_S2: begin scl = 1'b0; done = 1'b1; end
          PH_T1: enter_phase(PH_T2);
          PH_T2: done = 1'b1;
          PH_W1: enter_phase(PH_W2);
          PH_W2: enter_phase(PH_W3);
          PH_W3: begin
            shreg = {shreg[6:0], 1'b0};
            bits = bits + 4'd1;
            enter_phase((bits >= BITS_PER_BYTE) ? PH_A1 : PH_W1);
          end
          PH_A1: enter_phase(PH_A2);
          PH_A2: enter_phase(PH_A3);
          PH_R1: enter_phase(PH_R2);
          PH_K1: enter_phase(PH_K2);
          PH_K2: begin scl = 1'b0; done = 1'b1; end
          default: ph = PH_IDLE;
        endcase
      end
      // park the engine once a command finishes
      if (done) begin
        ph = PH_IDLE;
        timer = '0;
      end
      r.scl_level = scl;
      r.sda_level = sda;
      r.sda_drive = oe;
      r.busy = (ph != PH_IDLE);
      r.done = done;
      r.rx_byte = rx;
      r.nack_error = nack;
      levels_due.push_back(r);
    endfunction

    function void cmp_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_tick(res_t got);
      res_t want;
      if (levels_due.size() == 0) begin
        $error("result transaction with no tick outstanding");
        errors++;
        return;
      end
      want = levels_due.pop_front();
      cmp_field("scl_level", want.scl_level, got.scl_level);
      cmp_field("sda_level", want.sda_level, got.sda_level);
      cmp_field("sda_drive", want.sda_drive, got.sda_drive);
      cmp_field("busy_res", want.busy, got.busy);
      cmp_field("done_res", want.done, got.done);
      cmp_field("rx_byte", want.rx_byte, got.rx_byte);
      cmp_field("nack_error", want.nack_error, got.nack_error);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_t         in_op = OP_NONE;
  logic [7:0]  in_tx_byte = '0;
  logic        in_send_ack = 1'b0;
  logic        in_sda_sample = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_level;
  logic        out_sda_level;
  logic        out_sda_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_rx_byte;
  logic        out_nack_error;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_PHASE_TICKS;
  logic [15:0] cfg_data = '0;

  res_t          seen;
  bus_tick_board board;
  int            send_gap_pct = 26;
  int            recv_stall_pct = 82;
  int            ticks_left = 0;

  i2c_master_bit_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_tx_byte    (in_tx_byte),
    .in_send_ack   (in_send_ack),
    .in_sda_sample (in_sda_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .out_nack_error(out_nack_error),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  assign seen = {out_scl_level, out_sda_level, out_sda_drive, out_busy_res, out_done_res,
                 out_rx_byte, out_nack_error};

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_tick(seen);
  end

  // Present one tick, hold it until taken, then predict its result.
  task automatic send_tick(input op_t op, input logic [7:0] txb, input logic sack,
                           input logic sda_in);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_tx_byte <= txb;
    in_send_ack <= sack;
    in_sda_sample <= sda_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_tick(op, txb, sack, sda_in);
    ticks_left--;
  endtask

  // Issue a command and keep ticking until the engine goes idle or the budget runs out.
  task automatic run_cmd(input op_t op, input logic [7:0] txb, input logic sack,
                         input logic [7:0] reply, input bit acked);
    logic line;
    op_t  stray;
    send_tick(op, txb, sack, 1'($urandom_range(1)));
    while (board.ph != PH_IDLE && ticks_left > 0) begin
      case (board.ph)
        PH_A3: line = acked ? ($urandom_range(3) == 0) : ($urandom_range(199) != 0);
        PH_R1, PH_R2: line = reply[3'd7 - board.bits[2:0]];
        default: line = 1'($urandom_range(1));
      endcase
      stray = ($urandom_range(3) == 0) ? op_t'($urandom_range(OP_UNUSED7)) : OP_NONE;
      send_tick(stray, 8'($urandom_range(255)), 1'($urandom_range(1)), line);
    end
  endtask

  // Hold off the sender until every result has come back, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] ticks, input logic [15:0] timeout);
    cfg_we <= 1'b1;
    cfg_index <= REG_PHASE_TICKS;
    cfg_data <= ticks;
    @(posedge clk);
    board.set_reg(REG_PHASE_TICKS, ticks);
    cfg_index <= REG_ACK_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk);
    board.set_reg(REG_ACK_TIMEOUT, timeout);
    cfg_we <= 1'b0;
  endtask

  initial begin
    op_t         plan[$];
    op_t         noise;
    op_t         op;
    int          blk;
    logic [15:0] new_ticks;
    logic [15:0] new_timeout;

    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset levels, reset phase length, then each command and corner
    ticks_left = 32'h3FFF_FFFF;
    send_tick(OP_NONE, 8'h00, 1'b0, 1'b0);
    send_tick(OP_NONE, 8'hFF, 1'b1, 1'b1);
    run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 1'b1);
    drain();
    program_regs(16'd0, 16'd0);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1);
    run_cmd(OP_WRITE, 8'h00, 1'b1, 8'h00, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b1, 8'hFF, 1'b1);
    run_cmd(OP_READ, 8'hFF, 1'b0, 8'h00, 1'b1);
    for (int k = OP_UNUSED5; k <= OP_UNUSED7; k++) send_tick(op_t'(k), 8'hA5, 1'b1, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b1);
    drain();
    program_regs(16'd1, 16'd2);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0);
    run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 1'b1);
    drain();
    program_regs(16'd2, 16'hFFFF);
    run_cmd(OP_WRITE, 8'h5A, 1'b1, 8'h00, 1'b1);
    run_cmd(OP_READ, 8'h3C, 1'b1, 8'hC3, 1'b1);

    // random: mostly well-formed bus transactions, some stray and unused ops
    for (blk = 0; blk < 12; blk++) begin
      if (blk == 4) begin
        send_gap_pct = 82;
        recv_stall_pct = 26;
      end
      if (blk == 8) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      drain();
      case (blk)
        3: begin new_ticks = 16'd1; new_timeout = 16'd0; end
        6: begin new_ticks = 16'd0; new_timeout = 16'hFFFF; end
        9: begin
          new_ticks = 16'($urandom_range(3));
          new_timeout = 16'($urandom_range(16'hFFFF));
        end
        // the longest hold stays in the last block so it cannot starve the rest
        11: begin new_ticks = 16'hFFFF; new_timeout = 16'hFFFF; end
        default: begin
          new_ticks = 16'($urandom_range(3));
          new_timeout = 16'($urandom_range(5));
        end
      endcase
      program_regs(new_ticks, new_timeout);
      ticks_left = 105;
      while (ticks_left > 0) begin
        if (plan.size() == 0) begin
          if ($urandom_range(9) == 0) begin
            noise = op_t'($urandom_range(OP_READ, OP_UNUSED7));
            if (noise == OP_READ) noise = OP_NONE;
            send_tick(noise, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
          end else begin
            plan.push_back(OP_START);
            plan.push_back(OP_WRITE);
            repeat ($urandom_range(2)) plan.push_back($urandom_range(1) ? OP_WRITE : OP_READ);
            plan.push_back(OP_STOP);
            // break the odd transaction
            if ($urandom_range(7) == 0)
              plan[$urandom_range(plan.size() - 1)] = op_t'($urandom_range(OP_START, OP_READ));
          end
        end else begin
          op = plan.pop_front();
          run_cmd(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), ($urandom_range(3) != 0));
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0) begin
      $display("** i2c_master_bit_engine: PASSED **");
    end else begin
      $display("** i2c_master_bit_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("** i2c_master_bit_engine: FAILED **");
    $finish;
  end

endmodule

### i2c_master_bit_engine.f
+incdir+sv
sv/i2cm_pkg.sv
sv/i2c_master_bit_engine.sv
sv/i2cm_checker.sv
tb/testbench.sv
